/* rtl/ptl_pkg.sv */
// Package: shared types and codes for the periodic timer list.
package ptl_pkg;

	// Most fired results one tick may report
	localparam int unsigned MAX_RESULTS = 16;
	localparam int unsigned FIRE_CW     = $clog2(MAX_RESULTS + 1);

	typedef enum logic [1:0] {
		KIND_SET    = 2'd0,
		KIND_CANCEL = 2'd1,
		KIND_TICK   = 2'd2,
		KIND_UNUSED = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_ADDED      = 3'd0,
		ST_UPDATED    = 3'd1,
		ST_FULL       = 3'd2,
		ST_CANCELLED  = 3'd3,
		ST_NOT_FOUND  = 3'd4,
		ST_FIRED      = 3'd5,
		ST_NONE_FIRED = 3'd6,
		ST_RSVD       = 3'd7
	} status_t;

	// One command transfer
	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] timer_id;
		logic [63:0] due_time;
		logic [63:0] period;
		logic [31:0] callback_addr;
		logic [63:0] now_time;
	} cmd_t;

	// One response transfer
	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] fired_id;
		logic [31:0] fired_callback;
		logic        last;
	} rsp_t;

	// One timer slot as kept in the slot memory
	typedef struct packed {
		logic [31:0] id;
		logic [63:0] due;
		logic [63:0] period;
		logic [31:0] callback;
	} entry_t;

	// Write request into the slot memory (address travels beside it)
	typedef struct packed {
		logic   en;
		entry_t data;
	} wr_req_t;

endpackage

/* rtl/ptl_mem.sv */
// Slot memory: simple dual-port RAM, one write and one registered read per cycle.
module ptl_mem #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned AW    = 4
) (
	input  logic              clk,
	input  ptl_pkg::wr_req_t  wr,
	input  logic [AW-1:0]     waddr,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output ptl_pkg::entry_t   rdata
);

	ptl_pkg::entry_t mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[waddr] <= wr.data;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/periodic_timer_list.sv */
// Top level: ordered timer list kept in a slot memory, walked by a scan sequencer.
//
//   channel   direction  handshake                  payload
//   command   in         start && !busy             cmd (ptl_pkg::cmd_t)
//   response  out        rsp_valid, one cycle       rsp (ptl_pkg::rsp_t)
//
// Every set, cancel or tick holds busy while the pass reads each slot in turn through
// the single memory read port, takes the last read word, sees the pass drained and
// closes it; an empty list has no slot to read. Kept slots are written back
// compacted as they are read.
// A fired timer is reported once the next one fires; the final response shows in
// the first cycle after busy falls. The unused kind is taken without going busy, no response.
// Reset empties the list; slot contents are never cleared.
// The response port cannot be stalled; a response shows for one cycle only.
module periodic_timer_list #(
	parameter int unsigned TIMER_SLOTS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  ptl_pkg::cmd_t   cmd,
	output logic            rsp_valid,
	output ptl_pkg::rsp_t   rsp
);

	localparam int unsigned AW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
	localparam int unsigned CW = $clog2(TIMER_SLOTS + 1);

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_SCAN   = 3'b010,
		S_FINISH = 3'b100
	} state_t;

	state_t                      state_q;
	ptl_pkg::cmd_t               req_q;
	logic [CW-1:0]               count_q;
	logic [CW-1:0]               rd_ptr_q;
	logic [CW-1:0]               wr_ptr_q;
	logic                        valid_s1;
	logic                        found_q;
	logic [ptl_pkg::FIRE_CW-1:0] nfired_q;
	logic                        pend_v_q;
	logic [31:0]                 pend_id_q;
	logic [31:0]                 pend_cb_q;
	logic                        rsp_valid_q;
	ptl_pkg::rsp_t               rsp_q;

	ptl_pkg::entry_t  rd_entry;
	ptl_pkg::wr_req_t wr_c;
	logic [AW-1:0]    waddr_c;
	logic             rd_en;
	logic             id_hit;
	logic             due_hit;
	logic             keep;
	logic             can_add;
	ptl_pkg::entry_t  upd_entry;
	logic             rsp_valid_d;
	ptl_pkg::rsp_t    rsp_fin_c;

	ptl_mem #(
		.DEPTH (TIMER_SLOTS),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.wr    (wr_c),
		.waddr (waddr_c),
		.re    (rd_en),
		.raddr (rd_ptr_q[AW-1:0]),
		.rdata (rd_entry)
	);

	assign busy      = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign rd_en   = (state_q == S_SCAN) && (rd_ptr_q < count_q);
	assign can_add = (count_q < CW'(TIMER_SLOTS));

	// strobe: a held fired timer leaves when the next one fires, the final one at the close
	assign rsp_valid_d = (state_q == S_FINISH) ||
	                     (state_q == S_SCAN && valid_s1 &&
	                      req_q.kind == ptl_pkg::KIND_TICK && due_hit && pend_v_q);

	// per-slot decision on the word just read
	always_comb begin
		id_hit    = !found_q && (rd_entry.id == req_q.timer_id);
		due_hit   = (req_q.now_time >= rd_entry.due) &&
		            (nfired_q < ptl_pkg::FIRE_CW'(ptl_pkg::MAX_RESULTS));
		keep      = 1'b1;
		upd_entry = rd_entry;
		case (req_q.kind)
			ptl_pkg::KIND_SET: begin
				if (id_hit) begin
					upd_entry.due      = req_q.due_time;
					upd_entry.period   = req_q.period;
					upd_entry.callback = req_q.callback_addr;
				end
			end
			ptl_pkg::KIND_CANCEL: begin
				keep = !id_hit;
			end
			ptl_pkg::KIND_TICK: begin
				if (due_hit) begin
					keep          = (rd_entry.period != 64'd0);
					upd_entry.due = req_q.now_time + rd_entry.period;
				end
			end
			default: begin
				keep = 1'b1;
			end
		endcase
	end

	// memory write: compacted write-back during the pass, append at its close
	always_comb begin
		wr_c.en   = 1'b0;
		wr_c.data = upd_entry;
		waddr_c   = wr_ptr_q[AW-1:0];
		if (state_q == S_SCAN && valid_s1) begin
			wr_c.en = keep;
		end else if (state_q == S_FINISH && req_q.kind == ptl_pkg::KIND_SET &&
		             !found_q && can_add) begin
			wr_c.en   = 1'b1;
			wr_c.data = '{id: req_q.timer_id, due: req_q.due_time,
			              period: req_q.period, callback: req_q.callback_addr};
			waddr_c   = count_q[AW-1:0];
		end
	end

	// command register, no reset needed
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			req_q <= cmd;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rd_ptr_q    <= '0;
			wr_ptr_q    <= '0;
			valid_s1    <= 1'b0;
			found_q     <= 1'b0;
			nfired_q    <= '0;
			pend_v_q    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			rsp_valid_q <= rsp_valid_d;
			case (state_q)
				S_IDLE: begin
					if (start && cmd.kind != ptl_pkg::KIND_UNUSED) begin
						state_q  <= S_SCAN;
						rd_ptr_q <= '0;
						wr_ptr_q <= '0;
						valid_s1 <= 1'b0;
						found_q  <= 1'b0;
						nfired_q <= '0;
						pend_v_q <= 1'b0;
					end
				end
				S_SCAN: begin
					valid_s1 <= rd_en;
					if (rd_en) begin
						rd_ptr_q <= rd_ptr_q + CW'(1);
					end else if (!valid_s1) begin
						state_q <= S_FINISH;
					end
					if (valid_s1) begin
						if (keep) begin
							wr_ptr_q <= wr_ptr_q + CW'(1);
						end
						if (id_hit && req_q.kind != ptl_pkg::KIND_TICK) begin
							found_q <= 1'b1;
						end
						// fired timer: release the one held, hold this one
						if (req_q.kind == ptl_pkg::KIND_TICK && due_hit) begin
							nfired_q <= nfired_q + ptl_pkg::FIRE_CW'(1);
							pend_v_q <= 1'b1;
						end
					end
				end
				S_FINISH: begin
					state_q <= S_IDLE;
					if (req_q.kind == ptl_pkg::KIND_SET && !found_q && can_add) begin
						count_q <= wr_ptr_q + CW'(1);
					end else begin
						count_q <= wr_ptr_q;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// held fired timer
	always_ff @(posedge clk) begin
		if (state_q == S_SCAN && valid_s1 && req_q.kind == ptl_pkg::KIND_TICK &&
		    due_hit) begin
			pend_id_q <= rd_entry.id;
			pend_cb_q <= rd_entry.callback;
		end
	end

	// final response of a command
	always_comb begin
		rsp_fin_c = '{status: ptl_pkg::ST_NONE_FIRED, fired_id: 32'd0,
		              fired_callback: 32'd0, last: 1'b1};
		case (req_q.kind)
			ptl_pkg::KIND_SET: begin
				if (found_q) begin
					rsp_fin_c.status = ptl_pkg::ST_UPDATED;
				end else if (can_add) begin
					rsp_fin_c.status = ptl_pkg::ST_ADDED;
				end else begin
					rsp_fin_c.status = ptl_pkg::ST_FULL;
				end
			end
			ptl_pkg::KIND_CANCEL: begin
				rsp_fin_c.status = found_q ? ptl_pkg::ST_CANCELLED :
				                             ptl_pkg::ST_NOT_FOUND;
			end
			ptl_pkg::KIND_TICK: begin
				if (pend_v_q) begin
					rsp_fin_c.status         = ptl_pkg::ST_FIRED;
					rsp_fin_c.fired_id       = pend_id_q;
					rsp_fin_c.fired_callback = pend_cb_q;
				end
			end
			default: begin
				rsp_fin_c.status = ptl_pkg::ST_NONE_FIRED;
			end
		endcase
	end

	// response payload
	always_ff @(posedge clk) begin
		if (state_q == S_SCAN) begin
			rsp_q <= '{status: ptl_pkg::ST_FIRED, fired_id: pend_id_q,
			           fired_callback: pend_cb_q, last: 1'b0};
		end else if (state_q == S_FINISH) begin
			rsp_q <= rsp_fin_c;
		end
	end

endmodule

/* rtl/ptl_checker.sv */
// Checker: port-level properties of the timer list, bound to the top level.
module ptl_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input ptl_pkg::cmd_t cmd,
	input logic          rsp_valid,
	input ptl_pkg::rsp_t rsp
);

	// anything but a fired timer closes its command
	a_nonfire_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ptl_pkg::ST_FIRED |-> rsp.last)
		else $error("non-fired response without last");

	// ids and callbacks are zero unless a timer fired
	a_nonfire_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ptl_pkg::ST_FIRED |->
		rsp.fired_id == 32'd0 && rsp.fired_callback == 32'd0)
		else $error("non-fired response carries an id");

	// a real command transfer makes the block busy
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cmd.kind != ptl_pkg::KIND_UNUSED |=> busy)
		else $error("command taken but block not busy");

	// no response directly follows the final one
	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.last |=> !rsp_valid)
		else $error("response right after final response");

endmodule

bind periodic_timer_list ptl_checker u_ptl_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.cmd       (cmd),
	.rsp_valid (rsp_valid),
	.rsp       (rsp)
);
